// ===== design/hsws_pkg.sv =====
// ----------------------------------------------------------------------------
// hsws_pkg
// shared types and constants of the handle stack with slide
// ----------------------------------------------------------------------------
`default_nettype none

package hsws_pkg;

  // fixed field widths of the two channels
  localparam int unsigned OPCODE_BITS  = 3;
  localparam int unsigned HANDLE_IO_BITS = 32;
  localparam int unsigned AMOUNT_BITS  = 9;
  localparam int unsigned ENTRIES_BITS = 9;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_PEEK  = 3'd2,
    OP_DROP  = 3'd3,
    OP_SLIDE = 3'd4
  } opcode_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  // result handed from the controller to the output register
  typedef struct packed {
    logic                    load;
    logic                    use_mem;
    logic                    fault;
    logic [ENTRIES_BITS-1:0] entries;
  } resp_t;

endpackage

`default_nettype wire

// ===== design/hsws_if.sv =====
// ----------------------------------------------------------------------------
// hsws_if
// valid/ready channels for operations and results
// ----------------------------------------------------------------------------
`default_nettype none

interface hsws_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [hsws_pkg::OPCODE_BITS-1:0]       opcode;
  logic [hsws_pkg::HANDLE_IO_BITS-1:0]    handle_in;
  logic [hsws_pkg::AMOUNT_BITS-1:0]       amount;

  modport source (output valid, output opcode, output handle_in, output amount,
                  input ready);
  modport sink   (input valid, input opcode, input handle_in, input amount,
                  output ready);
endinterface

interface hsws_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [hsws_pkg::HANDLE_IO_BITS-1:0]    handle_out;
  logic                                   fault;
  logic [hsws_pkg::ENTRIES_BITS-1:0]      entries;

  modport source (output valid, output handle_out, output fault, output entries,
                  input ready);
  modport sink   (input valid, input handle_out, input fault, input entries,
                  output ready);
endinterface

`default_nettype wire

// ===== design/hsws_ram.sv =====
// ----------------------------------------------------------------------------
// hsws_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module hsws_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/hsws_ctrl.sv =====
// ----------------------------------------------------------------------------
// hsws_ctrl
// operation decode, entry count, ram addressing and sequencing
// ----------------------------------------------------------------------------
`default_nettype none

module hsws_ctrl #(
  parameter int unsigned STACK_DEPTH = 256,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  hsws_in_if.sink                             in_ch,
  input  wire logic                           out_free,
  output logic                                ram_we,
  output logic [$clog2(STACK_DEPTH)-1:0]      ram_waddr,
  output logic [HANDLE_BITS-1:0]              ram_wdata,
  output logic                                ram_re,
  output logic [$clog2(STACK_DEPTH)-1:0]      ram_raddr,
  input  wire logic [HANDLE_BITS-1:0]         ram_rdata,
  output hsws_pkg::resp_t                     resp
);

  localparam int unsigned AW   = $clog2(STACK_DEPTH);
  localparam int unsigned CW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CMPW =
    ((CW > hsws_pkg::AMOUNT_BITS) ? CW : hsws_pkg::AMOUNT_BITS) + 1;
  localparam int unsigned XW   =
    (HANDLE_BITS > hsws_pkg::HANDLE_IO_BITS) ? HANDLE_BITS : hsws_pkg::HANDLE_IO_BITS;

  hsws_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    cnt_nxt;
  logic [AW-1:0]    slide_addr_r, slide_addr_nxt;
  logic             slide_r, slide_nxt;

  logic             accept;
  logic [CMPW-1:0]  cnt_w, amt_w, below_w, top_w, cnt_nxt_w;
  logic [XW-1:0]    handle_x;

  assign in_ch.ready = (state_r == hsws_pkg::ST_IDLE) && out_free;
  assign accept      = in_ch.valid && in_ch.ready;

  assign cnt_w    = CMPW'(cnt_r);
  assign amt_w    = CMPW'(in_ch.amount);
  assign top_w    = cnt_w - CMPW'(1);
  assign below_w  = cnt_w - amt_w - CMPW'(1);
  assign handle_x = XW'(in_ch.handle_in);
  assign cnt_nxt  = cnt_nxt_w[CW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hsws_pkg::ST_IDLE;
      cnt_r   <= '0;
      slide_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      slide_r <= slide_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slide_addr_r <= slide_addr_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt_w      = cnt_w;
    slide_nxt      = slide_r;
    slide_addr_nxt = slide_addr_r;
    ram_we         = 1'b0;
    ram_waddr      = cnt_r[AW-1:0];
    ram_wdata      = handle_x[HANDLE_BITS-1:0];
    ram_re         = 1'b0;
    ram_raddr      = top_w[AW-1:0];
    resp           = '0;

    case (state_r)
      hsws_pkg::ST_IDLE: begin
        if (accept) begin
          resp.load = 1'b1;
          case (hsws_pkg::opcode_t'(in_ch.opcode))
            hsws_pkg::OP_PUSH: begin
              if (cnt_r == CW'(STACK_DEPTH)) begin
                resp.fault = 1'b1;
              end else begin
                ram_we    = 1'b1;
                cnt_nxt_w = cnt_w + CMPW'(1);
              end
            end
            hsws_pkg::OP_POP: begin
              if (cnt_r == '0) begin
                resp.fault = 1'b1;
              end else begin
                ram_re    = 1'b1;
                cnt_nxt_w = top_w;
                slide_nxt = 1'b0;
                state_nxt = hsws_pkg::ST_READ;
                resp.load = 1'b0;
              end
            end
            hsws_pkg::OP_PEEK: begin
              if (cnt_w <= amt_w) begin
                resp.fault = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = below_w[AW-1:0];
                slide_nxt = 1'b0;
                state_nxt = hsws_pkg::ST_READ;
                resp.load = 1'b0;
              end
            end
            hsws_pkg::OP_DROP: begin
              if (cnt_w < amt_w) begin
                resp.fault = 1'b1;
              end else begin
                cnt_nxt_w = cnt_w - amt_w;
              end
            end
            hsws_pkg::OP_SLIDE: begin
              if (cnt_w <= amt_w) begin
                resp.fault = 1'b1;
              end else begin
                ram_re         = 1'b1;
                slide_addr_nxt = below_w[AW-1:0];
                cnt_nxt_w      = cnt_w - amt_w;
                slide_nxt      = 1'b1;
                state_nxt      = hsws_pkg::ST_READ;
                resp.load      = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      hsws_pkg::ST_READ: begin
        // entry is back from the ram: hand it out, or copy it down for slide
        ram_we       = slide_r;
        ram_waddr    = slide_addr_r;
        ram_wdata    = ram_rdata;
        resp.load    = 1'b1;
        resp.use_mem = !slide_r;
        state_nxt    = hsws_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = hsws_pkg::ST_IDLE;
      end
    endcase

    resp.entries = cnt_nxt_w[hsws_pkg::ENTRIES_BITS-1:0];
  end

endmodule

`default_nettype wire

// ===== design/handle_stack_with_slide.sv =====
// ----------------------------------------------------------------------------
// handle_stack_with_slide
// fixed-depth stack of node handles with push, pop, peek, drop and slide
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------
//  in_chan  | in  | valid/ready        | opcode[2:0] handle_in[31:0] amount[8:0]
//  out_chan | out | valid/ready        | handle_out[31:0] fault entries[8:0]
//
//  push, drop, unknown opcodes and faulting operations load the result directly;
//  pop, peek and slide first wait for the registered read of the handle ram
//  one transaction in flight at a time; the result register frees the input
//  side, so a new transaction is taken while the last result is being taken
//  rst_n (synchronous) empties the stack at once; ram contents are not cleared
//  out_chan stalls hold the result and block input only once it is full
//
`default_nettype none

module handle_stack_with_slide #(
  parameter int unsigned STACK_DEPTH = 256,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hsws_in_if.sink    in_chan,
  hsws_out_if.source out_chan
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned XW =
    (HANDLE_BITS > hsws_pkg::HANDLE_IO_BITS) ? HANDLE_BITS : hsws_pkg::HANDLE_IO_BITS;

  // ram port between controller and store
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [HANDLE_BITS-1:0] ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [HANDLE_BITS-1:0] ram_rdata;
  logic [XW-1:0]          rdata_x;

  hsws_pkg::resp_t        resp;
  logic                   out_free;

  // result register
  logic                                   out_valid_r;
  logic [hsws_pkg::HANDLE_IO_BITS-1:0]    handle_r;
  logic                                   fault_r;
  logic [hsws_pkg::ENTRIES_BITS-1:0]      entries_r;

  // slot is free when empty or when its transaction completes this cycle
  assign out_free = !out_valid_r || out_chan.ready;

  hsws_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_chan),
    .out_free  (out_free),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .resp      (resp)
  );

  // handle store
  hsws_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // handle leaves through its low bits, zero extended when narrow
  assign rdata_x = XW'(ram_rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp.load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp.load) begin
      handle_r  <= resp.use_mem ? rdata_x[hsws_pkg::HANDLE_IO_BITS-1:0] : '0;
      fault_r   <= resp.fault;
      entries_r <= resp.entries;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.handle_out = handle_r;
  assign out_chan.fault      = fault_r;
  assign out_chan.entries    = entries_r;

endmodule

`default_nettype wire
